// File: hw/rtl/bkrd_pkg.sv
package bkrd_pkg;

  localparam int KEY_SLOTS   = 6;
  localparam int INPUT_SLOTS = 6;
  localparam int PAD_SLOTS   = (KEY_SLOTS > INPUT_SLOTS) ? KEY_SLOTS : INPUT_SLOTS;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] KEY_CAPS_LOCK   = 8'h39;
  localparam logic [7:0] KEY_NUM_LOCK    = 8'h53;
  localparam logic [7:0] KEY_SCROLL_LOCK = 8'h47;
  localparam logic [7:0] MOD_SHIFT_MASK  = 8'h22;

  localparam logic EVENT_KEY = 1'b0;
  localparam logic EVENT_LED = 1'b1;

  typedef struct packed {
    logic [KEY_SLOTS-1:0][7:0] codes;
    logic [KEY_SLOTS-1:0]      fresh;
    logic                      shift;
  } bkrd_entry_t;

  typedef struct packed {
    logic        valid;
    bkrd_entry_t entry;
  } bkrd_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bkrd_qstat_t;

endpackage

// File: hw/rtl/bkrd_front.sv
module bkrd_front
  import bkrd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  modifier_bits_i,
  input  logic [7:0]  key_slot0_i,
  input  logic [7:0]  key_slot1_i,
  input  logic [7:0]  key_slot2_i,
  input  logic [7:0]  key_slot3_i,
  input  logic [7:0]  key_slot4_i,
  input  logic [7:0]  key_slot5_i,
  input  bkrd_qstat_t qstat_i,
  output bkrd_push_t  push_o
);

  logic [PAD_SLOTS-1:0][7:0] in_arr;
  logic [KEY_SLOTS-1:0][7:0] slots;
  logic [KEY_SLOTS-1:0][7:0] prev_q;
  logic [KEY_SLOTS-1:0]      fresh;
  logic                      accept;

  always_comb begin
    in_arr    = '0;
    in_arr[0] = key_slot0_i;
    in_arr[1] = key_slot1_i;
    in_arr[2] = key_slot2_i;
    in_arr[3] = key_slot3_i;
    in_arr[4] = key_slot4_i;
    in_arr[5] = key_slot5_i;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      slots[i] = in_arr[i];
    end
  end

  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      fresh[i] = (slots[i] != 8'h00);
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (prev_q[j] == slots[i]) begin
          fresh[i] = 1'b0;
        end
      end
    end
  end

  assign in_ready_o = !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    push_o             = '0;
    push_o.valid       = accept && (fresh != '0);
    push_o.entry.codes = slots;
    push_o.entry.fresh = fresh;
    push_o.entry.shift = ((modifier_bits_i & MOD_SHIFT_MASK) != 8'h00);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (accept) begin
      prev_q <= slots;
    end
  end

endmodule

// File: hw/rtl/bkrd_queue.sv
module bkrd_queue
  import bkrd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  bkrd_push_t  push_i,
  input  logic        pop_i,
  output bkrd_entry_t head_o,
  output bkrd_qstat_t qstat_o
);

  bkrd_entry_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]       count_q, count_d;
  logic                    do_push;
  logic                    do_pop;

  assign qstat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign qstat_o.empty = (count_q == '0);
  assign head_o        = mem_q[rd_ptr_q];

  assign do_push = push_i.valid && !qstat_o.full;
  assign do_pop  = pop_i && !qstat_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

// File: hw/rtl/bkrd_back.sv
module bkrd_back
  import bkrd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  bkrd_entry_t head_i,
  input  bkrd_qstat_t qstat_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        event_kind_o,
  output logic [7:0]  key_code_o,
  output logic        shift_active_o,
  output logic [2:0]  led_bits_o,
  output logic        last_event_o
);

  bkrd_entry_t          cur_q, cur_d;
  logic                 caps_q, caps_d;
  logic                 num_q, num_d;
  logic                 scroll_q, scroll_d;
  logic                 out_valid_q, out_valid_d;
  logic                 kind_q, kind_d;
  logic [7:0]           code_q, code_d;
  logic                 shift_q, shift_d;
  logic [2:0]           led_q, led_d;
  logic                 last_q, last_d;
  logic [KEY_SLOTS-1:0] low;
  logic [KEY_SLOTS-1:0] rest;
  logic [7:0]           code;
  logic                 busy;
  logic                 fire;

  assign busy  = (cur_q.fresh != '0);
  assign fire  = busy && (!out_valid_q || out_ready_i);
  assign pop_o = !busy && !qstat_i.empty;
  assign low   = cur_q.fresh & (~cur_q.fresh + 1'b1);
  assign rest  = cur_q.fresh & ~low;

  always_comb begin
    code = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      code = code | (cur_q.codes[i] & {8{low[i]}});
    end
  end

  always_comb begin
    cur_d       = cur_q;
    caps_d      = caps_q;
    num_d       = num_q;
    scroll_d    = scroll_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    code_d      = code_q;
    shift_d     = shift_q;
    led_d       = led_q;
    last_d      = last_q;
    if (pop_o) begin
      cur_d = head_i;
    end else if (fire) begin
      cur_d.fresh = rest;
      out_valid_d = 1'b1;
      code_d      = code;
      last_d      = (rest == '0);
      kind_d      = EVENT_LED;
      shift_d     = 1'b0;
      priority if (code == KEY_CAPS_LOCK) begin
        caps_d = !caps_q;
      end else if (code == KEY_NUM_LOCK) begin
        num_d = !num_q;
      end else if (code == KEY_SCROLL_LOCK) begin
        scroll_d = !scroll_q;
      end else begin
        kind_d  = EVENT_KEY;
        shift_d = cur_q.shift ^ caps_q;
      end
      led_d = (kind_d == EVENT_LED) ? {scroll_d, caps_d, num_d} : 3'b000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      caps_q      <= 1'b0;
      num_q       <= 1'b0;
      scroll_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      caps_q      <= caps_d;
      num_q       <= num_d;
      scroll_q    <= scroll_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    code_q  <= code_d;
    shift_q <= shift_d;
    led_q   <= led_d;
    last_q  <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = kind_q;
  assign key_code_o     = code_q;
  assign shift_active_o = shift_q;
  assign led_bits_o     = led_q;
  assign last_event_o   = last_q;

endmodule

// File: hw/rtl/boot_keyboard_report_decoder_top.sv
// Channel   Handshake             Payload
// -------   -------------------   --------------------------------------------------
// report    in_valid_i/in_ready_o modifier_bits_i, key_slot0_i .. key_slot5_i
// event     out_valid_o/out_ready_i event_kind_o, key_code_o, shift_active_o,
//                                 led_bits_o, last_event_o
//
// A report's new presses are found against the stored previous report in the
// cycle in which it is accepted. A report with n new presses is then written into
// the two-entry queue and waits there until the event unit loads it, and the event
// unit registers one event a cycle while its output is not stalled, so the report
// gives n events, the last of them marked by last_event_o.
// Reset clears the previous report, the lock flags and the queue.
// The report side stalls only when the queue is full; a stalled event holds.
module boot_keyboard_report_decoder_top
  import bkrd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] modifier_bits_i,
  input  logic [7:0] key_slot0_i,
  input  logic [7:0] key_slot1_i,
  input  logic [7:0] key_slot2_i,
  input  logic [7:0] key_slot3_i,
  input  logic [7:0] key_slot4_i,
  input  logic [7:0] key_slot5_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       event_kind_o,
  output logic [7:0] key_code_o,
  output logic       shift_active_o,
  output logic [2:0] led_bits_o,
  output logic       last_event_o
);

  bkrd_push_t  push;
  bkrd_qstat_t qstat;
  bkrd_entry_t head;
  logic        pop;

  bkrd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .modifier_bits_i (modifier_bits_i),
    .key_slot0_i     (key_slot0_i),
    .key_slot1_i     (key_slot1_i),
    .key_slot2_i     (key_slot2_i),
    .key_slot3_i     (key_slot3_i),
    .key_slot4_i     (key_slot4_i),
    .key_slot5_i     (key_slot5_i),
    .qstat_i         (qstat),
    .push_o          (push)
  );

  bkrd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  bkrd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .qstat_i        (qstat),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_kind_o   (event_kind_o),
    .key_code_o     (key_code_o),
    .shift_active_o (shift_active_o),
    .led_bits_o     (led_bits_o),
    .last_event_o   (last_event_o)
  );

endmodule
